// File: hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, operation and status codes,
// and the transaction and cell types shared by all modules. No dependencies.

package spq_pkg;

	localparam int CAPACITY   = 16;
	localparam int SCORE_BITS = 8;
	localparam int ID_BITS    = 16;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_POP      = 2'd1,
		OP_PEEK     = 2'd2,
		OP_CONTAINS = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                   op;
		logic [SCORE_BITS-1:0] score;
		logic [ID_BITS-1:0]    payload_id;
	} in_item_t;

	typedef struct packed {
		status_t               status;
		logic                  found;
		logic [SCORE_BITS-1:0] head_score;
		logic [ID_BITS-1:0]    head_id;
		logic [COUNT_BITS-1:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic [SCORE_BITS-1:0] score;
		logic [ID_BITS-1:0]    id;
	} entry_t;

	typedef struct packed {
		logic                  insert;
		logic                  pop;
		logic [SCORE_BITS-1:0] score;
		logic [ID_BITS-1:0]    id;
	} cell_cmd_t;

endpackage

// File: hw/rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus the
// occupancy counter and the result register. Depends on spq_pkg and spq_cell.
//
//   channel   direction  handshake                 payload
//   command   in         start high, busy low      cmd    (spq_pkg::in_item_t)
//   result    out        done strobe, one cycle    result (spq_pkg::out_item_t)
//
// Every slot compares against the command and shifts in the same cycle, so a
// transaction is taken in every cycle and its result is registered, appearing in the next cycle.
// busy never rises; the cell chain settles each operation before the next one is taken.
// Reset clears the occupancy count and the result strobe; slot contents are
// left as they are and are never read until written.

module sorted_priority_queue_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spq_pkg::in_item_t  cmd,
	output logic               done,
	output spq_pkg::out_item_t result
);

	logic [spq_pkg::COUNT_BITS-1:0] count_q;
	logic                           done_q;
	spq_pkg::out_item_t             result_q;

	spq_pkg::cell_cmd_t   cell_cmd;
	spq_pkg::entry_t      entries [spq_pkg::CAPACITY];
	logic [spq_pkg::CAPACITY-1:0] lands;
	logic [spq_pkg::CAPACITY-1:0] hits;

	logic               accept;
	logic               full;
	logic               empty;
	logic               do_insert;
	logic               do_pop;
	spq_pkg::out_item_t result_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == spq_pkg::COUNT_BITS'(spq_pkg::CAPACITY));
	assign empty  = (count_q == '0);

	assign do_insert = accept && (cmd.op == spq_pkg::OP_INSERT) && !full;
	assign do_pop    = accept && (cmd.op == spq_pkg::OP_POP) && !empty;

	assign cell_cmd.insert = do_insert;
	assign cell_cmd.pop    = do_pop;
	assign cell_cmd.score  = cmd.score;
	assign cell_cmd.id     = cmd.payload_id;

	for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
		logic            left_lands;
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;

		if (i == 0) begin : g_first
			assign left_lands = 1'b0;
			assign left_entry = entries[i];
		end else begin : g_inner_left
			assign left_lands = lands[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == spq_pkg::CAPACITY - 1) begin : g_last
			assign right_entry = entries[i];
		end else begin : g_inner_right
			assign right_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cell_cmd),
			.occupied    (count_q > spq_pkg::COUNT_BITS'(i)),
			.left_lands  (left_lands),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entries[i]),
			.lands       (lands[i]),
			.match       (hits[i])
		);
	end

	always_comb begin
		result_d             = '0;
		result_d.status      = spq_pkg::STATUS_OK;
		result_d.entry_count = count_q;
		unique case (cmd.op)
			spq_pkg::OP_INSERT: begin
				if (full) begin
					result_d.status = spq_pkg::STATUS_FULL;
				end else begin
					result_d.entry_count = count_q + 1'b1;
				end
			end
			spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
				if (empty) begin
					result_d.status = spq_pkg::STATUS_EMPTY;
				end else begin
					result_d.found      = 1'b1;
					result_d.head_score = entries[0].score;
					result_d.head_id    = entries[0].id;
					if (cmd.op == spq_pkg::OP_POP) begin
						result_d.entry_count = count_q - 1'b1;
					end
				end
			end
			spq_pkg::OP_CONTAINS: begin
				result_d.found = |hits;
			end
			default: begin
				result_d.status = spq_pkg::STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.

module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic              occupied,
	input  logic              left_lands,
	input  spq_pkg::entry_t   left_entry,
	input  spq_pkg::entry_t   right_entry,
	output spq_pkg::entry_t   entry,
	output logic              lands,
	output logic              match
);

	spq_pkg::entry_t entry_q;

	// The new entry lands at or before this slot when the slot is empty or
	// holds a strictly lower score, so equal scores stay in arrival order.
	assign lands = !occupied || (entry_q.score < cmd.score);
	assign match = occupied && (entry_q.score == cmd.score);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (left_lands) begin
				entry_q <= left_entry;
			end else if (lands) begin
				entry_q.score <= cmd.score;
				entry_q.id    <= cmd.id;
			end
		end else if (cmd.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: hw/rtl/spq_checker.sv
// Port-level checks for sorted_priority_queue_unit, attached with a bind.
// Depends on spq_pkg.

module spq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input spq_pkg::in_item_t  cmd,
	input logic               done,
	input spq_pkg::out_item_t result
);

	// Every accepted transaction yields exactly one result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without a transaction");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.entry_count <= spq_pkg::COUNT_BITS'(spq_pkg::CAPACITY)))
		else $error("entry count above capacity");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != spq_pkg::STATUS_OK) |->
			(!result.found && result.head_score == '0 && result.head_id == '0))
		else $error("rejected transaction carries head data");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == spq_pkg::OP_INSERT) |=>
			(result.status == spq_pkg::STATUS_FULL || result.entry_count != '0))
		else $error("successful insert left the queue empty");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

// File: tb/sv/tb_sorted_priority_queue_unit.sv
// Self-checking testbench for sorted_priority_queue_unit: directed and random
// insert, pop, peek and contains transactions, checked against a behavioral
// sorted-queue model. Depends on spq_pkg and the RTL of the unit.

module tb_sorted_priority_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int RANDOM_ITEMS   = 1625;
	localparam int STALL_LIMIT    = 2000;
	localparam int PHASE_ONE_END  = 550;
	localparam int PHASE_TWO_END  = 1100;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  cmd;
	logic      done;
	out_item_t result;

	in_item_t  pending [$];
	out_item_t results_due [$];
	entry_t    slots [CAPACITY];
	int        held;
	int        sent;
	int        quiet_cycles;
	int        mismatches;

	sorted_priority_queue_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	function automatic out_item_t apply_op(in_item_t c);
		out_item_t r;
		int        pos;
		r = '0;
		r.status = STATUS_OK;
		case (c.op)
			OP_INSERT: begin
				if (held >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else begin
					pos = 0;
					while (pos < held && slots[pos].score >= c.score)
						pos++;
					for (int i = held; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos].score = c.score;
					slots[pos].id    = c.payload_id;
					held++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (held == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					r.found      = 1'b1;
					r.head_score = slots[0].score;
					r.head_id    = slots[0].id;
					if (c.op == OP_POP) begin
						for (int i = 1; i < held; i++)
							slots[i-1] = slots[i];
						held--;
					end
				end
			end
			default: begin
				for (int i = 0; i < held; i++)
					if (slots[i].score == c.score)
						r.found = 1'b1;
			end
		endcase
		r.entry_count = COUNT_BITS'(held);
		return r;
	endfunction

	task automatic queue_op(op_t o, logic [SCORE_BITS-1:0] s, logic [ID_BITS-1:0] id);
		in_item_t c;
		c.op         = o;
		c.score      = s;
		c.payload_id = id;
		pending.push_back(c);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic build_stimulus();
		int                    ins_pct;
		int                    narrow;
		int                    base;
		int                    len;
		int                    made;
		int                    r;
		logic [SCORE_BITS-1:0] s;
		op_t                   o;
		queue_op(OP_PEEK, 8'hFF, 16'hFFFF);
		queue_op(OP_POP, 8'h00, 16'h0000);
		queue_op(OP_CONTAINS, 8'h00, 16'hFFFF);
		queue_op(OP_INSERT, 8'h00, 16'h0000);
		queue_op(OP_INSERT, 8'hFF, 16'hFFFF);
		queue_op(OP_INSERT, 8'h80, 16'h1111);
		queue_op(OP_INSERT, 8'h80, 16'h2222);
		queue_op(OP_INSERT, 8'hFF, 16'h3333);
		queue_op(OP_INSERT, 8'h00, 16'h4444);
		for (int i = 0; i < 10; i++)
			queue_op(OP_INSERT, 8'(i * 23 + 5), 16'(16'hA5A5 ^ (i << 3)));
		queue_op(OP_INSERT, 8'h7F, 16'h5A5A);
		queue_op(OP_CONTAINS, 8'h80, 16'h0000);
		queue_op(OP_CONTAINS, 8'h01, 16'h0000);
		queue_op(OP_PEEK, 8'h00, 16'h0000);
		queue_op(OP_POP, 8'h00, 16'h0000);
		queue_op(OP_POP, 8'hFF, 16'hFFFF);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			r       = $urandom_range(2);
			ins_pct = (r == 0) ? 80 : (r == 1) ? 50 : 20;
			narrow  = $urandom_range(1);
			base    = $urandom_range(255);
			len     = $urandom_range(8, 40);
			for (int k = 0; k < len && made < RANDOM_ITEMS; k++) begin
				r = $urandom_range(99);
				if (r < ins_pct) begin
					o = OP_INSERT;
				end else begin
					case ($urandom_range(2))
						0: o = OP_POP;
						1: o = OP_PEEK;
						default: o = OP_CONTAINS;
					endcase
				end
				r = $urandom_range(19);
				if (r == 0)
					s = '0;
				else if (r == 1)
					s = '1;
				else if (narrow != 0)
					s = 8'(base ^ $urandom_range(3));
				else
					s = 8'($urandom_range(255));
				queue_op(o, s, 16'($urandom));
				made++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		held       = 0;
		sent       = 0;
		mismatches = 0;
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		do
			@(posedge clk);
		while (pending.size() != 0 || results_due.size() != 0);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb_sorted_priority_queue_unit: PASS");
		else
			$display("tb_sorted_priority_queue_unit: FAIL");
		$finish;
	end

	always @(negedge clk) begin : driver
		int idle_pct;
		idle_pct = (sent < PHASE_ONE_END) ? 10 : (sent < PHASE_TWO_END) ? 76 : 0;
		if (!arst_n || pending.size() == 0 || $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd   <= in_item_t'($urandom);
		end else begin
			start <= 1'b1;
			cmd   <= pending[0];
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		logic      took;
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				results_due.push_back(apply_op(cmd));
				void'(pending.pop_front());
				sent++;
			end
			if (done) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with none expected, expected none, actual 0x%0h",
						$time, result);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("found", 32'(want.found), 32'(result.found));
					check_field("head_score", 32'(want.head_score),
						32'(result.head_score));
					check_field("head_id", 32'(want.head_id), 32'(result.head_id));
					check_field("entry_count", 32'(want.entry_count),
						32'(result.entry_count));
				end
			end
			if (took || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding", $time, results_due.size());
				$display("tb_sorted_priority_queue_unit: FAIL");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

endmodule
